// ----- rtl/mdts_pkg.sv -----
// Package with shared types and default sizes for the multi-deque task store.
package mdts_pkg;

    localparam int NUM_DEQUES_DEF  = 16;
    localparam int DEQUE_DEPTH_DEF = 64;
    localparam int TASK_WIDTH_DEF  = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_W  = 2;
    localparam int ID_IN_W = 4;
    localparam int WORD_W = 32;
    localparam int OCC_W  = 7;

    typedef enum logic [1:0] {
        OP_PUSH_RIGHT = 2'd0,
        OP_PUSH_LEFT  = 2'd1,
        OP_POP_RIGHT  = 2'd2,
        OP_POP_LEFT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic             wr;
        logic             rd;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
    } ctl_t;

endpackage

// ----- rtl/multi_deque_task_store_top.sv -----
// Top level of the multi-deque task store.
// A bank of NUM_DEQUES double-ended task queues, each a ring of DEQUE_DEPTH
// task words; every request gives exactly one result, in request order. The
// block takes one request per clock cycle while the command queue has room and
// passes each result through a command queue entry and the result register.
// That rate is set by the single storage memory port, which reads on every
// request and also writes on a push, while the ring indices and fill counts sit
// in registers that the front end updates in the cycle of acceptance. A
// four-entry command queue lets the front end keep accepting while the result
// side stalls. Storage contents are undefined after reset and need no clearing pass.
module multi_deque_task_store_top
    import mdts_pkg::*;
#(
    parameter int NUM_DEQUES  = NUM_DEQUES_DEF,
    parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
    parameter int TASK_WIDTH  = TASK_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // deque_id[3:0], task_word[35:4], zero pad.
    input  logic [1:0]  s_tuser,  // req_type[1:0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // popped_task[31:0], occupancy[38:32], zero pad.
    output logic [1:0]  m_tuser   // status[1:0].
);

    localparam int ADDR_W  = $clog2(NUM_DEQUES * DEQUE_DEPTH);
    localparam int ENTRY_W = $bits(ctl_t) + ADDR_W + TASK_WIDTH;

    logic                  f_push;
    logic                  q_ready;
    ctl_t                  f_ctl;
    logic [ADDR_W-1:0]     f_addr;
    logic [TASK_WIDTH-1:0] f_data;
    logic                  q_valid;
    logic                  q_pop;
    logic [ENTRY_W-1:0]    q_dout;
    ctl_t                  b_ctl;
    logic [ADDR_W-1:0]     b_addr;
    logic [TASK_WIDTH-1:0] b_data;
    logic [WORD_W-1:0]     r_task;
    status_t               r_status;
    logic [OCC_W-1:0]      r_occ;

    mdts_front #(
        .NUM_DEQUES  (NUM_DEQUES),
        .DEQUE_DEPTH (DEQUE_DEPTH),
        .TASK_WIDTH  (TASK_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (op_t'(s_tuser)),
        .req_id    (s_tdata[3:0]),
        .req_word  (s_tdata[35:4]),
        .cmd_push  (f_push),
        .cmd_ready (q_ready),
        .cmd_ctl   (f_ctl),
        .cmd_addr  (f_addr),
        .cmd_data  (f_data)
    );

    mdts_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_push),
        .ready   (q_ready),
        .din     ({f_ctl, f_addr, f_data}),
        .valid   (q_valid),
        .pop     (q_pop),
        .dout    (q_dout)
    );

    assign {b_ctl, b_addr, b_data} = q_dout;

    mdts_back #(
        .NUM_DEQUES  (NUM_DEQUES),
        .DEQUE_DEPTH (DEQUE_DEPTH),
        .TASK_WIDTH  (TASK_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_valid),
        .cmd_pop       (q_pop),
        .cmd_ctl       (b_ctl),
        .cmd_addr      (b_addr),
        .cmd_data      (b_data),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_task      (r_task),
        .res_status    (r_status),
        .res_occupancy (r_occ)
    );

    assign m_tdata = {1'b0, r_occ, r_task};
    assign m_tuser = r_status;

endmodule

// ----- rtl/mdts_front.sv -----
// Front end: accepts requests, keeps the per-deque ring indices and fill counts.
module mdts_front
    import mdts_pkg::*;
#(
    parameter int NUM_DEQUES  = NUM_DEQUES_DEF,
    parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
    parameter int TASK_WIDTH  = TASK_WIDTH_DEF,
    parameter int ADDR_W      = $clog2(NUM_DEQUES_DEF * DEQUE_DEPTH_DEF)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  op_t                   req_op,
    input  logic [ID_IN_W-1:0]    req_id,
    input  logic [WORD_W-1:0]     req_word,
    output logic                  cmd_push,
    input  logic                  cmd_ready,
    output ctl_t                  cmd_ctl,
    output logic [ADDR_W-1:0]     cmd_addr,
    output logic [TASK_WIDTH-1:0] cmd_data
);

    localparam int ID_W = (NUM_DEQUES > 1) ? $clog2(NUM_DEQUES) : 1;
    localparam int PW   = $clog2(DEQUE_DEPTH);
    localparam int CW   = $clog2(DEQUE_DEPTH + 1);

    logic [PW-1:0] left_reg  [NUM_DEQUES];
    logic [PW-1:0] right_reg [NUM_DEQUES];
    logic [CW-1:0] fill_reg  [NUM_DEQUES];

    logic [ID_W-1:0] idx;
    logic            id_ok;
    logic            is_pop;
    logic [PW-1:0]   left_cur;
    logic [PW-1:0]   right_cur;
    logic [CW-1:0]   fill_cur;
    logic [PW-1:0]   left_next;
    logic [PW-1:0]   right_next;
    logic [CW-1:0]   fill_next;
    logic [PW-1:0]   pos;
    logic            upd;
    ctl_t            ctl;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(DEQUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEQUE_DEPTH - 1) : p - PW'(1);
    endfunction

    assign idx       = ID_W'(req_id);
    assign id_ok     = (32'(req_id) < NUM_DEQUES);
    assign is_pop    = req_op[1];
    assign left_cur  = left_reg[idx];
    assign right_cur = right_reg[idx];
    assign fill_cur  = fill_reg[idx];

    always_comb begin
        ctl        = '{wr: 1'b0, rd: 1'b0, status: ST_OK, occupancy: '0};
        left_next  = left_cur;
        right_next = right_cur;
        fill_next  = fill_cur;
        pos        = '0;
        upd        = 1'b0;
        priority if (!id_ok) begin
            ctl.status = is_pop ? ST_EMPTY : ST_FULL;
        end else if (!is_pop && fill_cur == CW'(DEQUE_DEPTH)) begin
            ctl.status = ST_FULL;
        end else if (is_pop && fill_cur == '0) begin
            ctl.status = ST_EMPTY;
        end else begin
            upd = 1'b1;
            unique case (req_op)
                OP_PUSH_RIGHT: begin
                    pos        = right_cur;
                    right_next = ring_next(right_cur);
                    fill_next  = fill_cur + CW'(1);
                    ctl.wr     = 1'b1;
                end
                OP_PUSH_LEFT: begin
                    pos       = ring_prev(left_cur);
                    left_next = pos;
                    fill_next = fill_cur + CW'(1);
                    ctl.wr    = 1'b1;
                end
                OP_POP_RIGHT: begin
                    pos        = ring_prev(right_cur);
                    right_next = pos;
                    fill_next  = fill_cur - CW'(1);
                    ctl.rd     = 1'b1;
                end
                OP_POP_LEFT: begin
                    pos       = left_cur;
                    left_next = ring_next(left_cur);
                    fill_next = fill_cur - CW'(1);
                    ctl.rd    = 1'b1;
                end
                default: begin
                    upd = 1'b0;
                end
            endcase
        end
        if (id_ok) begin
            ctl.occupancy = OCC_W'(fill_next);
        end
    end

    assign req_ready = cmd_ready;
    assign cmd_push  = req_valid && cmd_ready;
    assign cmd_ctl   = ctl;
    assign cmd_addr  = ADDR_W'(int'(idx) * DEQUE_DEPTH + int'(pos));
    assign cmd_data  = TASK_WIDTH'(req_word);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DEQUES; i++) begin
                left_reg[i]  <= '0;
                right_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
        end else if (cmd_push && upd) begin
            left_reg[idx]  <= left_next;
            right_reg[idx] <= right_next;
            fill_reg[idx]  <= fill_next;
        end
    end

endmodule

// ----- rtl/mdts_queue.sv -----
// Short command queue between the front end and the storage back end.
module mdts_queue
    import mdts_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    output logic         ready,
    input  logic [W-1:0] din,
    output logic         valid,
    input  logic         pop,
    output logic [W-1:0] dout
);

    logic [W-1:0]           entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ready) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid) else $error("queue read while empty");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + QUEUE_CNT_W'(1))
        else $error("queue count did not advance on write");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with an empty count");

endmodule

// ----- rtl/mdts_back.sv -----
// Back end: task storage memory and the result register.
module mdts_back
    import mdts_pkg::*;
#(
    parameter int NUM_DEQUES  = NUM_DEQUES_DEF,
    parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
    parameter int TASK_WIDTH  = TASK_WIDTH_DEF,
    parameter int ADDR_W      = $clog2(NUM_DEQUES_DEF * DEQUE_DEPTH_DEF)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  ctl_t                  cmd_ctl,
    input  logic [ADDR_W-1:0]     cmd_addr,
    input  logic [TASK_WIDTH-1:0] cmd_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [WORD_W-1:0]     res_task,
    output status_t               res_status,
    output logic [OCC_W-1:0]      res_occupancy
);

    localparam int MEM_DEPTH = NUM_DEQUES * DEQUE_DEPTH;

    logic [TASK_WIDTH-1:0] mem [MEM_DEPTH];
    logic [TASK_WIDTH-1:0] rdata_reg;
    ctl_t                  ctl_reg;
    logic                  valid_reg;

    assign cmd_pop = cmd_valid && (!valid_reg || res_ready);

    always_ff @(posedge aclk) begin
        if (cmd_pop && cmd_ctl.wr) begin
            mem[cmd_addr] <= cmd_data;
        end
        if (cmd_pop) begin
            rdata_reg <= mem[cmd_addr];
            ctl_reg   <= cmd_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd_pop) begin
            valid_reg <= 1'b1;
        end else if (res_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign res_valid     = valid_reg;
    assign res_task      = ctl_reg.rd ? WORD_W'(rdata_reg) : '0;
    assign res_status    = ctl_reg.status;
    assign res_occupancy = ctl_reg.occupancy;

endmodule
